// ===== hdl/omf_ssp_pkg.sv =====
package omf_ssp_pkg;

  localparam logic [7:0]  TYPE_SEGDEF = 8'h98;
  localparam logic [7:0]  TYPE_MODEND = 8'h8A;
  localparam logic [28:0] TOTAL_MAX   = 29'h1FFF_FFFF;
  localparam logic [16:0] BIG_SIZE    = 17'h1_0000;

  localparam logic [15:0] RECORD_LIMIT_RST  = 16'd5000;
  localparam logic [12:0] SEGMENT_LIMIT_RST = 13'd250;

  typedef enum logic [0:0] {
    CFG_RECORD_LIMIT  = 1'b0,
    CFG_SEGMENT_LIMIT = 1'b1
  } cfg_addr_e;

  typedef enum logic [1:0] {
    KIND_SEGMENT = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CHECKSUM  = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_TOO_MANY  = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_e;

  typedef struct packed {
    logic [12:0] segment_count;
    logic [28:0] total_size;
    logic [14:0] name_index;
    logic [16:0] segment_size;
    status_e     status;
    kind_e       kind;
  } result_t;

endpackage

// ===== hdl/omf_ssp_core.sv =====
module omf_ssp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  logic                 eoi_i,
  input  logic [15:0]          record_limit_i,
  input  logic [12:0]          segment_limit_i,
  output logic                 res_vld_o,
  output omf_ssp_pkg::result_t res_o
);
  import omf_ssp_pkg::*;

  typedef enum logic [1:0] {
    PH_TYPE   = 2'd0,
    PH_LEN_LO = 2'd1,
    PH_LEN_HI = 2'd2,
    PH_BODY   = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  csum_q, csum_d;
  logic [7:0]  attr_q, attr_d;
  logic [7:0]  fb_q [4];
  logic [7:0]  fb_d [4];
  logic [28:0] total_q, total_d;
  logic [12:0] count_q, count_d;
  logic        halted_q, halted_d;

  logic        finish;
  logic [3:0]  field_off;
  logic [3:0]  field_rel;
  logic [16:0] seg_size;
  logic [14:0] seg_index;
  logic [29:0] total_sum;

  // where the size field starts, given the acbp alignment code
  always_comb begin
    unique case (attr_q[7:5])
      3'b000, 3'b101: field_off = 4'd4;
      3'b110:         field_off = 4'd6;
      default:        field_off = 4'd1;
    endcase
  end

  assign field_rel = pos_q[3:0] - field_off;

  always_comb begin
    phase_d  = phase_q;
    type_d   = type_q;
    len_d    = len_q;
    pos_d    = pos_q;
    csum_d   = csum_q;
    attr_d   = attr_q;
    fb_d     = fb_q;
    total_d  = total_q;
    count_d  = count_q;
    halted_d = halted_q;
    finish   = 1'b0;
    res_vld_o = 1'b0;
    res_o.kind          = KIND_ERROR;
    res_o.status        = ST_OK;
    res_o.segment_size  = '0;
    res_o.name_index    = '0;
    seg_size  = '0;
    seg_index = '0;
    total_sum = '0;

    if (step_i && !halted_q) begin
      if (eoi_i) begin
        halted_d  = 1'b1;
        res_vld_o = 1'b1;
        if (phase_q == PH_TYPE) begin
          res_o.kind = KIND_SUMMARY;
        end else begin
          res_o.status = ST_TRUNCATED;
        end
      end else begin
        unique case (phase_q)
          PH_TYPE: begin
            type_d  = byte_i;
            csum_d  = byte_i;
            len_d   = '0;
            pos_d   = '0;
            attr_d  = '0;
            for (int i = 0; i < 4; i++) fb_d[i] = '0;
            phase_d = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            len_d   = {8'h00, byte_i};
            csum_d  = csum_q + byte_i;
            phase_d = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            len_d  = {byte_i, len_q[7:0]};
            csum_d = csum_q + byte_i;
            if (len_d >= record_limit_i) begin
              halted_d     = 1'b1;
              res_vld_o    = 1'b1;
              res_o.status = ST_TOO_LONG;
            end else if (len_d == '0) begin
              finish = 1'b1;
            end else begin
              phase_d = PH_BODY;
            end
          end
          PH_BODY: begin
            csum_d = csum_q + byte_i;
            if (pos_q == '0) begin
              attr_d = byte_i;
            end else if (pos_q[15:4] == '0 && pos_q[3:0] >= field_off &&
                         field_rel[3:2] == 2'b00) begin
              fb_d[field_rel[1:0]] = byte_i;
            end
            pos_d = pos_q + 16'd1;
            if (pos_d == len_q) finish = 1'b1;
          end
          default: phase_d = PH_TYPE;
        endcase

        if (finish) begin
          phase_d = PH_TYPE;
          seg_size  = attr_d[1] ? BIG_SIZE : {1'b0, fb_d[1], fb_d[0]};
          seg_index = fb_d[2][7] ? {fb_d[2][6:0], fb_d[3]} : {7'b0, fb_d[2]};
          total_sum = {1'b0, total_q} + {13'b0, seg_size};
          priority if (csum_d != 8'h00) begin
            halted_d     = 1'b1;
            res_vld_o    = 1'b1;
            res_o.status = ST_CHECKSUM;
          end else if (type_q == TYPE_MODEND) begin
            halted_d   = 1'b1;
            res_vld_o  = 1'b1;
            res_o.kind = KIND_SUMMARY;
          end else if (type_q == TYPE_SEGDEF) begin
            res_vld_o = 1'b1;
            if (count_q >= segment_limit_i) begin
              halted_d     = 1'b1;
              res_o.status = ST_TOO_MANY;
            end else begin
              total_d = total_sum[29] ? TOTAL_MAX : total_sum[28:0];
              count_d = count_q + 13'd1;
              res_o.kind         = KIND_SEGMENT;
              res_o.segment_size = seg_size;
              res_o.name_index   = seg_index;
            end
          end else begin
            res_vld_o = 1'b0;
          end
        end
      end
    end

    res_o.total_size    = total_d;
    res_o.segment_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TYPE;
      type_q   <= '0;
      len_q    <= '0;
      pos_q    <= '0;
      csum_q   <= '0;
      attr_q   <= '0;
      for (int i = 0; i < 4; i++) fb_q[i] <= '0;
      total_q  <= '0;
      count_q  <= '0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      csum_q   <= csum_d;
      attr_q   <= attr_d;
      fb_q     <= fb_d;
      total_q  <= total_d;
      count_q  <= count_d;
      halted_q <= halted_d;
    end
  end

endmodule

// ===== hdl/omf_segment_size_parser_unit.sv =====
// omf segment size parser: frames an omf-86 object file and reports segment sizes
//
// slave stream: one byte of the file per word; tuser high marks end of file
// (the data byte of that word is ignored). master stream: at most one word per
// input byte - a segment definition, a final summary (modend or end of file
// between records) or an error. tuser carries the kind, tdata the status,
// segment size, name index, running total and segment count.
// an accepted byte lands in the input register; the combinational state update
// then writes its result, if any, into the output register, which drives tvalid.
// throughput is one byte per cycle while the master side does not stall.
// reset clears all parser state and loads the default limits (5000, 250).
// after a summary or an error the parser is halted: bytes are still taken but
// give no words until the next reset.
// if the master side stalls, the output word holds; one more byte may enter
// the input register, then tready drops until the output word is taken.
// the user must write limits on the cfg port only while the stream is idle;
// the block itself does not enforce this.
module omf_segment_size_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tuser_i,   // end_of_input
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status, segment_size, name_index, total_size, segment_count, 3 bits zero fill
  output logic [79:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,   // result_kind
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);
  import omf_ssp_pkg::*;

  logic [15:0] record_limit_q;
  logic [12:0] segment_limit_q;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_eoi_q;
  logic        advance;

  logic        res_vld;
  result_t     res;

  logic        out_valid_q;
  result_t     out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_limit_q  <= RECORD_LIMIT_RST;
      segment_limit_q <= SEGMENT_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_e'(cfg_addr_i))
        CFG_RECORD_LIMIT:  record_limit_q  <= cfg_wdata_i;
        CFG_SEGMENT_LIMIT: segment_limit_q <= cfg_wdata_i[12:0];
        default:           record_limit_q  <= record_limit_q;
      endcase
    end
  end

  // the input word moves on when the output register is free or being emptied
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_eoi_q  <= s_axis_tuser_i;
    end
  end

  omf_ssp_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .byte_i          (in_byte_q),
    .eoi_i           (in_eoi_q),
    .record_limit_i  (record_limit_q),
    .segment_limit_i (segment_limit_q),
    .res_vld_o       (res_vld),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_vld) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {3'b000, out_q.segment_count, out_q.total_size,
                            out_q.name_index, out_q.segment_size, out_q.status};

  // a summary or error word halts the parser, so nothing follows it
  a_nothing_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && m_axis_tready_i && out_q.kind != KIND_SEGMENT |=> !out_valid_q)
    else $error("word emitted after final summary or error");

  // a segment word always reports ok and a non-zero count
  a_segment_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_SEGMENT |->
      out_q.status == ST_OK && out_q.segment_count != '0)
    else $error("segment word with bad status or count");

  // a byte waiting in the input register is never overwritten
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q) && $stable(in_eoi_q))
    else $error("input register overwritten while stalled");

endmodule
